>>> rtl/sparse_weight_update_decoder_top_macros.svh
// Assertion macros shared by the sparse weight update decoder RTL.
// Expects clk and rst_n in the scope where a macro is used.
`ifndef SPARSE_WEIGHT_UPDATE_DECODER_TOP_MACROS_SVH
`define SPARSE_WEIGHT_UPDATE_DECODER_TOP_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define SWUD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define SWUD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/swud_pkg.sv
// Types and constants of the sparse weight update decoder.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package swud_pkg;

  // Configuration register indexes
  localparam logic [1:0] CFG_SECTION_STRIDE    = 2'd0;
  localparam logic [1:0] CFG_LENGTH_FIELD_BITS = 2'd1;
  localparam logic [1:0] CFG_INDEX_SHIFT       = 2'd2;

  localparam logic [15:0] RST_SECTION_STRIDE    = 16'd804;
  localparam logic [3:0]  RST_LENGTH_FIELD_BITS = 4'd5;
  localparam logic [3:0]  RST_INDEX_SHIFT       = 4'd5;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,  // section or header byte
    PH_HDR_LO = 2'd1,  // header low byte
    PH_WT_HI  = 2'd2,  // weight high byte
    PH_WT_LO  = 2'd3   // weight low byte
  } swud_phase_t;

  typedef struct packed {
    logic [7:0] packet_byte;
    logic       first_of_packet;
  } swud_in_t;

  typedef struct packed {
    logic [15:0]        weight_position;
    logic signed [15:0] weight_value;
  } swud_out_t;

  // One decoded weight waiting for its position
  typedef struct packed {
    logic [15:0] word;
    logic [6:0]  section;
    logic [14:0] index;
    logic [14:0] offset;
  } swud_job_t;

  typedef struct packed {
    logic empty;
    logic full;
  } swud_q_stat_t;

endpackage

>>> rtl/swud_front.sv
// Byte parser: tracks section, run header and weight bytes, emits weight jobs.
// Depends on swud_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "sparse_weight_update_decoder_top_macros.svh"

module swud_front
  import swud_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        accept,
  input  swud_in_t    in_item,
  input  logic [3:0]  length_field_bits,
  input  logic [3:0]  index_shift,
  output logic        push,
  output swud_job_t   job
);

  swud_phase_t phase_r, phase_nxt;
  logic [7:0]  held_r, held_nxt;
  logic [6:0]  sec_r, sec_nxt;
  logic [14:0] idx_r, idx_nxt;
  logic [14:0] len_r, len_nxt;
  logic [14:0] off_r, off_nxt;

  // state as seen after an optional packet restart
  swud_phase_t eff_phase;
  logic [7:0]  eff_held;
  logic [6:0]  eff_sec;
  logic [14:0] eff_idx;
  logic [14:0] eff_len;
  logic [14:0] eff_off;

  logic [7:0]  b;
  logic [14:0] hdr;
  logic [14:0] hdr_idx;
  logic [15:0] len_mask;
  logic [14:0] hdr_len;
  logic [15:0] off_inc;
  logic        run_done;

  assign b = in_item.packet_byte;

  always_comb begin
    if (in_item.first_of_packet) begin
      eff_phase = PH_IDLE;
      eff_held  = '0;
      eff_sec   = '0;
      eff_idx   = '0;
      eff_len   = '0;
      eff_off   = '0;
    end else begin
      eff_phase = phase_r;
      eff_held  = held_r;
      eff_sec   = sec_r;
      eff_idx   = idx_r;
      eff_len   = len_r;
      eff_off   = off_r;
    end
  end

  assign hdr      = {eff_held[6:0], b};
  assign hdr_idx  = hdr >> index_shift;
  assign len_mask = (16'd1 << length_field_bits) - 16'd1;
  assign hdr_len  = hdr & len_mask[14:0];
  assign off_inc  = {1'b0, eff_off} + 16'd1;
  assign run_done = off_inc >= {1'b0, eff_len};

  // next state
  always_comb begin
    phase_nxt = eff_phase;
    held_nxt  = eff_held;
    sec_nxt   = eff_sec;
    idx_nxt   = eff_idx;
    len_nxt   = eff_len;
    off_nxt   = eff_off;
    case (eff_phase)
      PH_IDLE: begin
        if (!b[7]) begin
          sec_nxt = b[6:0];
        end else begin
          held_nxt  = b;
          phase_nxt = PH_HDR_LO;
        end
      end
      PH_HDR_LO: begin
        idx_nxt   = hdr_idx;
        len_nxt   = hdr_len;
        off_nxt   = '0;
        phase_nxt = (hdr_len == '0) ? PH_IDLE : PH_WT_HI;
      end
      PH_WT_HI: begin
        held_nxt  = b;
        phase_nxt = PH_WT_LO;
      end
      PH_WT_LO: begin
        if (run_done) begin
          off_nxt   = '0;
          len_nxt   = '0;
          phase_nxt = PH_IDLE;
        end else begin
          off_nxt   = off_inc[14:0];
          phase_nxt = PH_WT_HI;
        end
      end
      default: phase_nxt = PH_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    job.word    = {eff_held, b};
    job.section = eff_sec;
    job.index   = eff_idx;
    job.offset  = eff_off;
    case (eff_phase)
      PH_WT_LO: push = accept;
      default:  push = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      held_r  <= '0;
      sec_r   <= '0;
      idx_r   <= '0;
      len_r   <= '0;
      off_r   <= '0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      held_r  <= held_nxt;
      sec_r   <= sec_nxt;
      idx_r   <= idx_nxt;
      len_r   <= len_nxt;
      off_r   <= off_nxt;
    end
  end

  // a weight phase always has a nonempty run with the offset inside it
  `SWUD_ASSERT_NOW(a_run_nonempty, (phase_r == PH_WT_HI) || (phase_r == PH_WT_LO), off_r < len_r, "weight phase with offset outside run")
  `SWUD_ASSERT_NEXT(a_idle_after_last, accept && push && run_done, phase_r == PH_IDLE, "last weight of run did not return to idle")

endmodule

>>> rtl/swud_queue.sv
// Short FIFO of weight jobs between the parser and the position unit.
// Depends on swud_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "sparse_weight_update_decoder_top_macros.svh"

module swud_queue
  import swud_pkg::*;
#(
  parameter int DEPTH = 4  // 2 or more
)
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  swud_job_t    push_job,
  input  logic         pop,
  output swud_job_t    head_job,
  output swud_q_stat_t stat
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  swud_job_t        mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign stat.empty = (count_r == '0);
  assign stat.full  = (count_r == CNT_W'(DEPTH));
  assign head_job   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    case ({push, pop})
      2'b10:   count_nxt = count_r + CNT_W'(1);
      2'b01:   count_nxt = count_r - CNT_W'(1);
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  `SWUD_ASSERT_NOW(a_no_overflow, push, !stat.full, "push into full queue")
  `SWUD_ASSERT_NOW(a_no_underflow, pop, !stat.empty, "pop from empty queue")

endmodule

>>> rtl/swud_back.sv
// Position unit: stride*section multiply, add of index and offset, output register.
// Depends on swud_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "sparse_weight_update_decoder_top_macros.svh"

module swud_back
  import swud_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic [15:0]  section_stride,
  input  swud_job_t    head_job,
  input  swud_q_stat_t q_stat,
  output logic         pop,
  output logic         out_valid,
  output swud_out_t    out_data,
  input  logic         out_stall
);

  logic        s1_v_r, s1_v_nxt;
  logic [15:0] s1_prod_r;
  logic [15:0] s1_io_r;
  logic [15:0] s1_word_r;
  logic        s2_v_r, s2_v_nxt;
  swud_out_t   s2_r;

  logic        s2_ready;
  logic        s1_ready;
  logic [22:0] prod_full;
  logic [15:0] io_sum;

  assign s2_ready = !s2_v_r || !out_stall;
  assign s1_ready = !s1_v_r || s2_ready;
  assign pop      = !q_stat.empty && s1_ready;

  assign prod_full = {7'd0, section_stride} * {16'd0, head_job.section};
  assign io_sum    = {1'b0, head_job.index} + {1'b0, head_job.offset};

  always_comb begin
    s1_v_nxt = s1_v_r;
    if (s1_ready) begin
      s1_v_nxt = pop;
    end
    s2_v_nxt = s2_v_r;
    if (s2_ready) begin
      s2_v_nxt = s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
      s2_v_r <= s2_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      s1_prod_r <= prod_full[15:0];
      s1_io_r   <= io_sum;
      s1_word_r <= head_job.word;
    end
    if (s2_ready && s1_v_r) begin
      s2_r.weight_position <= s1_prod_r + s1_io_r;
      s2_r.weight_value    <= s1_word_r;
    end
  end

  assign out_valid = s2_v_r;
  assign out_data  = s2_r;

  `SWUD_ASSERT_NEXT(a_stage1_flows, s1_v_r && s2_ready, s2_v_r, "stage 1 result lost on advance")

endmodule

>>> rtl/sparse_weight_update_decoder_top.sv
// A weight goes from its low byte through the job queue, stage 1 and stage 2 to out_valid.
// Throughput: one byte per cycle; in_stall rises only when the job queue is full.
// The rate is set by the parser, which handles one byte a cycle, and the back pipeline,
// which finishes one weight a cycle unless stalled (one 16x7 multiply stage, one add stage).
// Reset: rst_n synchronous, active low; clears parser, queue and pipeline valids and
// loads the register defaults (stride 804, length bits 5, index shift 5).
`timescale 1ns / 1ps

module sparse_weight_update_decoder_top
  import swud_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4  // weight jobs buffered between parser and position unit
)
(
  input  logic        clk,
  input  logic        rst_n,
  // packet byte channel
  input  logic        in_valid,
  output logic        in_stall,
  input  swud_in_t    in_data,
  // weight update channel
  output logic        out_valid,
  input  logic        out_stall,
  output swud_out_t   out_data,
  // configuration writes
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);

  logic [15:0] stride_r, stride_nxt;
  logic [3:0]  lfb_r, lfb_nxt;
  logic [3:0]  ishift_r, ishift_nxt;

  logic         in_accept;
  logic         push;
  swud_job_t    push_job;
  swud_job_t    head_job;
  logic         pop;
  swud_q_stat_t q_stat;

  // Configuration registers. Writes must happen only with the block idle (the block
  // does not enforce this), so the parser and position unit read them directly.
  always_comb begin
    stride_nxt = stride_r;
    lfb_nxt    = lfb_r;
    ishift_nxt = ishift_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_SECTION_STRIDE:    stride_nxt = cfg_wdata;
        CFG_LENGTH_FIELD_BITS: lfb_nxt    = cfg_wdata[3:0];
        CFG_INDEX_SHIFT:       ishift_nxt = cfg_wdata[3:0];
        default:               stride_nxt = stride_r;  // unmapped index: ignored
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stride_r <= RST_SECTION_STRIDE;
      lfb_r    <= RST_LENGTH_FIELD_BITS;
      ishift_r <= RST_INDEX_SHIFT;
    end else begin
      stride_r <= stride_nxt;
      lfb_r    <= lfb_nxt;
      ishift_r <= ishift_nxt;
    end
  end

  // The parser takes a transaction whenever the queue has room, even while the
  // output side is stalled; the queue absorbs the difference.
  assign in_stall  = q_stat.full;
  assign in_accept = in_valid && !in_stall;

  swud_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .accept            (in_accept),
    .in_item           (in_data),
    .length_field_bits (lfb_r),
    .index_shift       (ishift_r),
    .push              (push),
    .job               (push_job)
  );

  swud_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head_job (head_job),
    .stat     (q_stat)
  );

  // Position = stride*section + index + offset, modulo 2^16, then the output
  // register holds the transaction until out_stall drops.
  swud_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .section_stride (stride_r),
    .head_job       (head_job),
    .q_stat         (q_stat),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_data       (out_data),
    .out_stall      (out_stall)
  );

endmodule

>>> sim/tb_sparse_weight_update_decoder_top.sv
// Testbench for sparse_weight_update_decoder_top: byte-level parser checked against
// a local predictor of section/header/weight decoding. Depends on swud_pkg and the RTL.
`timescale 1ns / 1ps

module tb_sparse_weight_update_decoder_top;
  import swud_pkg::*;

  localparam int unsigned HOLD_CYCLES  = 64;    // long receiver hold-off
  localparam int unsigned DRAIN_CYCLES = 6;     // settle time past the last weight
  localparam int unsigned QUIET_LIMIT  = 2000;  // cycles with no transaction at all

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  swud_in_t    in_data;
  logic        out_valid;
  logic        out_stall;
  swud_out_t   out_data;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_wdata;

  // Register copies seen by the predictor
  logic [15:0] stride_reg;
  logic [3:0]  len_bits_reg;
  logic [3:0]  shift_reg;

  // Parser state of the predictor
  swud_phase_t ph;
  logic [7:0]  held;
  logic [6:0]  sect;
  logic [14:0] r_idx;
  logic [14:0] r_len;
  logic [14:0] r_off;

  swud_out_t   pending_weights[$];  // weight updates predicted, not yet seen
  int unsigned err_count;
  int unsigned items_sent;
  int unsigned quiet_cycles;
  int unsigned gap_pct;             // chance per slot that the sender idles
  int unsigned stall_pct;           // chance per cycle that the receiver stalls
  logic        hold_req;            // asks the receiver for a long hold-off

  sparse_weight_update_decoder_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  task automatic report_mismatch(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    err_count++;
  endtask

  task automatic clear_parser();
    ph    = PH_IDLE;
    held  = '0;
    sect  = '0;
    r_idx = '0;
    r_len = '0;
    r_off = '0;
  endtask

  // Advance the predictor by one accepted byte; a weight low byte yields one update.
  task automatic decode_byte(input swud_in_t it);
    logic [14:0] hdr;
    logic [15:0] mask;
    logic [31:0] pos;
    swud_out_t   w;
    if (it.first_of_packet) clear_parser();
    case (ph)
      PH_IDLE: begin
        if (!it.packet_byte[7]) begin
          sect = it.packet_byte[6:0];
        end else begin
          held = it.packet_byte;
          ph   = PH_HDR_LO;
        end
      end
      PH_HDR_LO: begin
        hdr   = {held[6:0], it.packet_byte};
        r_idx = hdr >> shift_reg;
        mask  = (16'd1 << len_bits_reg) - 16'd1;
        r_len = hdr & mask[14:0];
        r_off = '0;
        ph    = (r_len == 15'd0) ? PH_IDLE : PH_WT_HI;
      end
      PH_WT_HI: begin
        held = it.packet_byte;
        ph   = PH_WT_LO;
      end
      default: begin
        pos = 32'(stride_reg) * 32'(sect) + 32'(r_idx) + 32'(r_off);
        w.weight_position = pos[15:0];
        w.weight_value    = {held, it.packet_byte};
        pending_weights.push_back(w);
        if ({1'b0, r_off} + 16'd1 >= {1'b0, r_len}) begin
          r_off = '0;
          r_len = '0;
          ph    = PH_IDLE;
        end else begin
          r_off = r_off + 15'd1;
          ph    = PH_WT_HI;
        end
      end
    endcase
  endtask

  // One input transaction. Entered and left at a falling edge; valid stays high on
  // exit so back-to-back calls keep the channel busy without a dip.
  task automatic send_byte(input logic [7:0] b, input logic first);
    swud_in_t it;
    it.packet_byte     = b;
    it.first_of_packet = first;
    while ($urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    decode_byte(it);
    items_sent++;
    @(negedge clk);
  endtask

  // Header plus weights of one run; the length field is forced to len, the rest of
  // the header is random. drop cuts trailing bytes off to leave the run unfinished.
  task automatic send_run(input int unsigned len, input logic first,
                          input int unsigned drop = 0);
    logic [15:0]  mask;
    logic [14:0]  hdr;
    int unsigned  nbytes;
    int unsigned  k;
    mask   = (16'd1 << len_bits_reg) - 16'd1;
    hdr    = (15'($urandom_range(0, 32767)) & ~mask[14:0]) | (15'(len) & mask[14:0]);
    nbytes = 2 + 2 * (hdr & mask[14:0]);
    nbytes = (drop >= nbytes) ? 1 : nbytes - drop;
    for (k = 0; k < nbytes; k++) begin
      if (k == 0) send_byte({1'b1, hdr[14:8]}, first);
      else if (k == 1) send_byte(hdr[7:0], 1'b0);
      else send_byte(8'($urandom), 1'b0);
    end
  endtask

  // A packet: opened by the restart flag, then sections and runs, with some noise
  // and cut-off runs mixed in.
  task automatic send_packet(input int unsigned max_len);
    int unsigned n;
    int unsigned k;
    if ($urandom_range(0, 3) == 0) send_run($urandom_range(0, max_len), 1'b1);
    else send_byte({1'b0, 7'($urandom_range(0, 127))}, 1'b1);
    n = $urandom_range(1, 4);
    for (k = 0; k < n; k++) begin
      case ($urandom_range(0, 11))
        0, 1: send_byte({1'b0, 7'($urandom_range(0, 127))}, 1'b0);
        2: repeat ($urandom_range(1, 5)) send_byte(8'($urandom), $urandom_range(0, 7) == 0);
        3: send_run($urandom_range(1, max_len), 1'b0, $urandom_range(1, 3));
        default: send_run($urandom_range(0, max_len), 1'b0);
      endcase
    end
  endtask

  // Sender pauses until every predicted weight update has been seen.
  task automatic wait_weights_drained();
    in_valid <= 1'b0;
    while (pending_weights.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_SECTION_STRIDE:    stride_reg   = val;
      CFG_LENGTH_FIELD_BITS: len_bits_reg = val[3:0];
      CFG_INDEX_SHIFT:       shift_reg    = val[3:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic load_setting(input logic [15:0] stride, input logic [3:0] len_bits,
                              input logic [3:0] shift);
    write_reg(CFG_SECTION_STRIDE, stride);
    write_reg(CFG_LENGTH_FIELD_BITS, {12'd0, len_bits});
    write_reg(CFG_INDEX_SHIFT, {12'd0, shift});
  endtask

  // Reset defaults: stride 804, 5 length bits, index shift 5.
  task automatic test_directed();
    send_byte(8'h7F, 1'b1);                          // highest section, restart flag
    send_byte(8'h80, 1'b0); send_byte(8'h21, 1'b0);  // index 1, length 1
    send_byte(8'h80, 1'b0); send_byte(8'h00, 1'b0);  // most negative weight, position wraps
    send_byte(8'h80, 1'b0); send_byte(8'h20, 1'b0);  // zero length: header only
    send_byte(8'h00, 1'b1);                          // section 0
    send_byte(8'hFF, 1'b0); send_byte(8'hE2, 1'b0);  // all-ones index, length 2
    send_byte(8'h7F, 1'b0); send_byte(8'hFF, 1'b0);  // most positive weight
    send_byte(8'hFF, 1'b0); send_byte(8'hFF, 1'b0);  // minus one
    send_byte(8'h85, 1'b0);                          // header left half done...
    send_byte(8'h03, 1'b1);                          // ...and dropped by a restart
    send_byte(8'h80, 1'b0); send_byte(8'h01, 1'b0);
    send_byte(8'h12, 1'b0);                          // weight left half done...
    send_byte(8'h81, 1'b1);                          // ...restart lands on a header byte
    send_byte(8'h00, 1'b0);
    send_byte(8'hC0, 1'b0); send_byte(8'h01, 1'b0);
    send_byte(8'h34, 1'b0); send_byte(8'h56, 1'b0);
  endtask

  // Register extremes, including a zero-bit length field.
  task automatic test_config_extremes();
    wait_weights_drained();
    load_setting(16'hFFFF, 4'd15, 4'd15);
    send_byte(8'h7F, 1'b1);
    send_run(3, 1'b0);
    send_run(0, 1'b0);
    wait_weights_drained();
    load_setting(16'h0000, 4'd1, 4'd0);
    send_byte(8'h7F, 1'b1);
    send_run(1, 1'b0);
    send_run(1, 1'b0);
    send_byte(8'h2A, 1'b0);
    send_run(1, 1'b0);
    wait_weights_drained();
    load_setting(16'd1234, 4'd0, 4'd3);
    send_byte(8'h05, 1'b1);
    send_run(2, 1'b0);                               // length always reads as zero
    send_byte(8'h40, 1'b0);
    send_run(0, 1'b0);
    wait_weights_drained();
    load_setting(16'hFFFF, 4'd4, 4'd0);
    send_byte(8'h7F, 1'b1);
    send_run(15, 1'b0);
  endtask

  // Receiver holds off while a long run streams in, so the job queue fills and
  // in_stall must rise; then the sender waits for every weight to come back.
  task automatic test_backpressure();
    int unsigned saved_gap;
    int unsigned saved_stall;
    saved_gap   = gap_pct;
    saved_stall = stall_pct;
    wait_weights_drained();
    load_setting(RST_SECTION_STRIDE, RST_LENGTH_FIELD_BITS, RST_INDEX_SHIFT);
    gap_pct   = 0;
    stall_pct = 0;
    send_byte(8'h11, 1'b1);
    hold_req = 1'b1;
    send_run(24, 1'b0);
    wait_weights_drained();
    send_run(3, 1'b0);
    gap_pct   = saved_gap;
    stall_pct = saved_stall;
  endtask

  // Three idle profiles, two register settings each.
  task automatic test_random();
    int unsigned mode;
    int unsigned seg;
    int unsigned target;
    for (mode = 0; mode < 3; mode++) begin
      case (mode)
        0: begin gap_pct = 27; stall_pct = 70; end
        1: begin gap_pct = 70; stall_pct = 27; end
        default: begin gap_pct = 0; stall_pct = 0; end
      endcase
      for (seg = 0; seg < 2; seg++) begin
        wait_weights_drained();
        load_setting(16'($urandom_range(0, 65535)), 4'($urandom_range(1, 15)),
                     4'($urandom_range(0, 15)));
        target = items_sent + 300;
        while (items_sent < target) send_packet(($urandom_range(0, 9) == 0) ? 12 : 4);
      end
    end
  endtask

  // Receiver side: random stalls, or one long hold-off on request.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // Every accepted weight update transaction is matched to the oldest prediction.
  always @(posedge clk) begin : check_weights
    swud_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_weights.size() == 0) begin
        report_mismatch($sformatf("unexpected weight update pos=%0d val=%0d",
                                  out_data.weight_position, out_data.weight_value));
      end else begin
        want = pending_weights.pop_front();
        if (out_data.weight_position !== want.weight_position)
          report_mismatch($sformatf("weight_position got %0d want %0d",
                                    out_data.weight_position, want.weight_position));
        if (out_data.weight_value !== want.weight_value)
          report_mismatch($sformatf("weight_value got %0d want %0d",
                                    out_data.weight_value, want.weight_value));
      end
    end
  end

  // Watchdog: ends the run if no transaction happens on either channel for too long.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles, %0d updates outstanding",
               QUIET_LIMIT, pending_weights.size());
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_data      = '0;
    cfg_we       = 1'b0;
    cfg_index    = CFG_SECTION_STRIDE;
    cfg_wdata    = '0;
    hold_req     = 1'b0;
    err_count    = 0;
    items_sent   = 0;
    quiet_cycles = 0;
    gap_pct      = 27;
    stall_pct    = 70;
    stride_reg   = RST_SECTION_STRIDE;
    len_bits_reg = RST_LENGTH_FIELD_BITS;
    shift_reg    = RST_INDEX_SHIFT;
    clear_parser();
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_directed();
    test_config_extremes();
    test_backpressure();
    test_random();

    wait_weights_drained();
    if (err_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

>>> sparse_weight_update_decoder_top.f
+incdir+rtl
rtl/swud_pkg.sv
rtl/swud_front.sv
rtl/swud_queue.sv
rtl/swud_back.sv
rtl/sparse_weight_update_decoder_top.sv
sim/tb_sparse_weight_update_decoder_top.sv
